// ===== design/lpef_pkg.sv =====
// Shared types and constants for the length-prefixed event frame parser.
`default_nettype none
package lpef_pkg;

  localparam int unsigned PREFIX_BYTES      = 4;
  localparam int unsigned BODY_HEADER_BYTES = 3;
  localparam int unsigned PRIO_POS          = 4;
  localparam int unsigned TOPIC_HI_POS      = 5;
  localparam int unsigned TOPIC_LO_POS      = 6;
  localparam int unsigned FIRST_BODY_POS    = 7;
  localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;
  localparam logic [7:0]  MAX_PRIORITY_RST  = 8'd3;

  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_TOPIC   = 2'd1,
    KIND_PAYLOAD = 2'd2
  } byte_kind_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_SHORT       = 3'd1,
    ERR_LEN_MISMATCH = 3'd2,
    ERR_BODY_SHORT  = 3'd3,
    ERR_BAD_PRIO    = 3'd4,
    ERR_TOPIC_OVER  = 3'd5,
    ERR_TOPIC_ZERO  = 3'd6
  } err_code_t;

  // Classified byte handed from the front end to the checker stage.
  typedef struct packed {
    logic [7:0]  data;
    byte_kind_t  kind;
    logic        last;
    logic [7:0]  prio;
    logic [15:0] topic_size;
    logic [31:0] total;
    logic [31:0] declared;
  } frame_rec_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_kind_t  kind;
    logic        done;
    logic [7:0]  prio;
    logic [15:0] topic_size;
    err_code_t   code;
  } result_t;

endpackage
`default_nettype wire

// ===== design/length_prefixed_event_frame_parser.sv =====
// Top level of the length-prefixed event frame parser.
//
// Input channel: push/full with data_byte and last_byte; one frame byte per
// transaction, last_byte high on the final byte of the frame.
// Result channel: empty/pop; one result per input byte, in order, carrying
// the byte, its kind, and on the final byte the priority, topic length and
// error code (zero on other bytes).
// Configuration: cfg_we/cfg_data write max_priority (reset value 3).
// Throughput: one byte per clock, sustained while the receiver keeps popping.
// An accepted byte is written into the middle queue, then moves through the
// checker stage into the output queue when that queue has room, and from
// there onto the result ports.
// Reset clears the frame counter, the captured header fields and both
// queues. When the receiver stops popping, the output queue fills, then the
// middle queue; full rises after MID_DEPTH + OUT_DEPTH bytes are held.
`default_nettype none
module length_prefixed_event_frame_parser #(
  parameter int unsigned MID_DEPTH = lpef_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = lpef_pkg::OUT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [1:0]       byte_kind,
  output logic             frame_done,
  output logic [7:0]       frame_priority,
  output logic [15:0]      topic_length,
  output logic [2:0]       error_code,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data
);
  import lpef_pkg::*;

  frame_rec_t in_rec;
  frame_rec_t mid_rec;
  result_t    res;
  result_t    out_res;
  logic       take;
  logic       mid_empty;
  logic       out_full;
  logic       advance;

  assign take    = push && !full;
  assign advance = !mid_empty && !out_full;

  lpef_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .rec       (in_rec)
  );

  lpef_fifo #(
    .WIDTH ($bits(frame_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (take),
    .wr_data (in_rec),
    .full    (full),
    .pop     (advance),
    .rd_data (mid_rec),
    .empty   (mid_empty)
  );

  lpef_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rec      (mid_rec),
    .res      (res)
  );

  lpef_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (advance),
    .wr_data (res),
    .full    (out_full),
    .pop     (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign out_byte       = out_res.data;
  assign byte_kind      = out_res.kind;
  assign frame_done     = out_res.done;
  assign frame_priority = out_res.prio;
  assign topic_length   = out_res.topic_size;
  assign error_code     = out_res.code;
endmodule
`default_nettype wire

// ===== design/lpef_fifo.sv =====
// Small synchronous register queue used between and after the parser stages.
`default_nettype none
module lpef_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/lpef_front.sv =====
// Front end: counts frame positions, captures header fields, tags each byte.
`default_nettype none
module lpef_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output lpef_pkg::frame_rec_t rec
);
  import lpef_pkg::*;

  logic [31:0] byte_count;
  logic [31:0] declared_length;
  logic [7:0]  held_priority;
  logic [15:0] held_topic_length;

  logic [31:0] byte_count_next;
  logic [31:0] declared_length_next;
  logic [7:0]  held_priority_next;
  logic [15:0] held_topic_length_next;
  logic [31:0] body_pos;
  byte_kind_t  kind;

  assign body_pos = byte_count - 32'(FIRST_BODY_POS);

  always_comb begin
    declared_length_next   = declared_length;
    held_priority_next     = held_priority;
    held_topic_length_next = held_topic_length;
    kind                   = KIND_HEADER;
    if (byte_count < 32'(PREFIX_BYTES)) begin
      declared_length_next = {declared_length[23:0], data_byte};
    end else if (byte_count == 32'(PRIO_POS)) begin
      held_priority_next = data_byte;
    end else if (byte_count == 32'(TOPIC_HI_POS)) begin
      held_topic_length_next = {data_byte, 8'h00};
    end else if (byte_count == 32'(TOPIC_LO_POS)) begin
      held_topic_length_next = {held_topic_length[15:8], data_byte};
    end else begin
      kind = (body_pos < {16'h0000, held_topic_length}) ? KIND_TOPIC : KIND_PAYLOAD;
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 32'd1;
  end

  always_comb begin
    rec.data       = data_byte;
    rec.kind       = kind;
    rec.last       = last_byte;
    rec.prio       = held_priority_next;
    rec.topic_size = held_topic_length_next;
    rec.total      = byte_count_next;
    rec.declared   = declared_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      declared_length   <= '0;
      held_priority     <= '0;
      held_topic_length <= '0;
    end else if (take) begin
      // Clear everything at the end of a frame.
      if (last_byte) begin
        byte_count        <= '0;
        declared_length   <= '0;
        held_priority     <= '0;
        held_topic_length <= '0;
      end else begin
        byte_count        <= byte_count_next;
        declared_length   <= declared_length_next;
        held_priority     <= held_priority_next;
        held_topic_length <= held_topic_length_next;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/lpef_back.sv =====
// Back end: runs the end-of-frame checks and builds the result record.
`default_nettype none
module lpef_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_data,
  input  wire lpef_pkg::frame_rec_t rec,
  output lpef_pkg::result_t     res
);
  import lpef_pkg::*;

  logic [7:0]  max_priority;
  logic [31:0] body_len;
  logic [32:0] need_len;
  err_code_t   code;

  assign body_len = rec.total - 32'(PREFIX_BYTES);
  assign need_len = 33'(BODY_HEADER_BYTES) + {17'h00000, rec.topic_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_priority <= MAX_PRIORITY_RST;
    end else if (cfg_we) begin
      max_priority <= cfg_data;
    end
  end

  // First failing check wins.
  always_comb begin
    if (rec.total < 32'(PREFIX_BYTES)) begin
      code = ERR_SHORT;
    end else if (rec.total == COUNT_MAX || rec.declared != body_len) begin
      code = ERR_LEN_MISMATCH;
    end else if (rec.declared < 32'(BODY_HEADER_BYTES)) begin
      code = ERR_BODY_SHORT;
    end else if (rec.prio > max_priority) begin
      code = ERR_BAD_PRIO;
    end else if ({1'b0, rec.declared} < need_len) begin
      code = ERR_TOPIC_OVER;
    end else if (rec.topic_size == 16'h0000) begin
      code = ERR_TOPIC_ZERO;
    end else begin
      code = ERR_OK;
    end
  end

  always_comb begin
    res.data       = rec.data;
    res.kind       = rec.kind;
    res.done       = rec.last;
    res.prio       = rec.last ? rec.prio : 8'h00;
    res.topic_size = rec.last ? rec.topic_size : 16'h0000;
    res.code       = rec.last ? code : ERR_OK;
  end
endmodule
`default_nettype wire

// ===== design/lpef_checker.sv =====
// Port-level checks for the frame parser, bound to the top level.
`default_nettype none
module lpef_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        full,
  input  wire logic        pop,
  input  wire logic        empty,
  input  wire logic [7:0]  out_byte,
  input  wire logic        frame_done,
  input  wire logic [7:0]  frame_priority,
  input  wire logic [15:0] topic_length,
  input  wire logic [2:0]  error_code
);
  import lpef_pkg::*;

  // Queues come out of reset drained and open.
  a_reset_drains: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  // Summary fields read zero away from the final byte.
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_done) |->
      (frame_priority == 8'h00 && topic_length == 16'h0000 &&
       error_code == ERR_OK))
    else $error("summary fields set on a non-final byte");

  // A frame reported clean has a nonzero topic length.
  a_ok_topic: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done && error_code == ERR_OK) |-> (topic_length != 16'h0000))
    else $error("clean frame with zero topic length");

  // Hold the head result while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(error_code)))
    else $error("head result changed while stalled");
endmodule

bind length_prefixed_event_frame_parser lpef_checker u_lpef_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the length-prefixed event frame parser: directed and random frames against predicted results.
`timescale 1ns / 1ps

module tb_top;
  import lpef_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class frame_scoreboard;
    logic [7:0]  max_prio;
    logic [31:0] count;
    logic [31:0] declared;
    logic [7:0]  prio;
    logic [15:0] tlen;
    result_t     pending[$];
    int          errors;

    function new();
      max_prio = MAX_PRIORITY_RST;
      count    = '0;
      declared = '0;
      prio     = '0;
      tlen     = '0;
      errors   = 0;
    endfunction

    function void set_max_priority(logic [7:0] v);
      max_prio = v;
    endfunction

    // Predict the result of one accepted byte and queue it.
    function void note_byte(logic [7:0] b, logic l);
      result_t     r;
      logic [31:0] pos;
      logic [31:0] total;
      logic [32:0] wide_decl;
      logic [32:0] wide_need;
      pos = count;
      r = '0;
      r.kind = KIND_HEADER;
      r.code = ERR_OK;
      if (pos < PREFIX_BYTES) begin
        declared = {declared[23:0], b};
      end else if (pos == PRIO_POS) begin
        prio = b;
      end else if (pos == TOPIC_HI_POS) begin
        tlen = {b, 8'h00};
      end else if (pos == TOPIC_LO_POS) begin
        tlen[7:0] = b;
      end else if ((pos - FIRST_BODY_POS) < {16'h0000, tlen}) begin
        r.kind = KIND_TOPIC;
      end else begin
        r.kind = KIND_PAYLOAD;
      end
      if (count != COUNT_MAX) count = count + 1;
      r.data = b;
      r.done = l;
      if (l) begin
        total = count;
        wide_decl = {1'b0, declared};
        wide_need = 33'(BODY_HEADER_BYTES) + {17'h0, tlen};
        if (total < PREFIX_BYTES) r.code = ERR_SHORT;
        else if (total == COUNT_MAX || declared != total - PREFIX_BYTES)
          r.code = ERR_LEN_MISMATCH;
        else if (declared < BODY_HEADER_BYTES) r.code = ERR_BODY_SHORT;
        else if (prio > max_prio) r.code = ERR_BAD_PRIO;
        else if (wide_decl < wide_need) r.code = ERR_TOPIC_OVER;
        else if (tlen == 16'h0000) r.code = ERR_TOPIC_ZERO;
        r.prio = prio;
        r.topic_size = tlen;
        // Clear for the next frame.
        count = '0;
        declared = '0;
        prio = '0;
        tlen = '0;
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [7:0] ob, logic [1:0] k, logic d, logic [7:0] p,
                               logic [15:0] t, logic [2:0] e);
      result_t x;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual byte %0h", $time, ob);
        return;
      end
      x = pending.pop_front();
      compare_field("out_byte", 32'(x.data), 32'(ob));
      compare_field("byte_kind", 32'(x.kind), 32'(k));
      compare_field("frame_done", 32'(x.done), 32'(d));
      compare_field("frame_priority", 32'(x.prio), 32'(p));
      compare_field("topic_length", 32'(x.topic_size), 32'(t));
      compare_field("error_code", 32'(x.code), 32'(e));
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 470;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        frame_done;
  logic [7:0]  frame_priority;
  logic [15:0] topic_length;
  logic [2:0]  error_code;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = 8'h00;

  frame_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  cur_max_prio = MAX_PRIORITY_RST;

  length_prefixed_event_frame_parser DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .last_byte(last_byte),
    .pop(pop), .empty(empty), .out_byte(out_byte), .byte_kind(byte_kind),
    .frame_done(frame_done), .frame_priority(frame_priority),
    .topic_length(topic_length), .error_code(error_code),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: stall at random, check every popped transaction.
  initial begin
    forever begin
      @(negedge clk);
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_result(out_byte, byte_kind, frame_done, frame_priority, topic_length,
                        error_code);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    // Hold the byte until the block takes it.
    do @(posedge clk); while (full);
    sb.note_byte(d, l);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t fb);
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic send_random_frame();
    byte_q_t      fb;
    int unsigned  mode;
    int unsigned  tl;
    int unsigned  n;
    logic [31:0]  decl;
    logic [7:0]   prio;
    logic         framed;
    mode = $urandom_range(0, 99);
    framed = 1'b1;
    tl = $urandom_range(0, 5);
    n = 0;
    if (mode < 60) begin
      if ($urandom_range(0, 9) == 0) tl = $urandom_range(0, 40);
      n = tl + $urandom_range(0, 8);
      decl = 32'(3 + n);
    end else if (mode < 70) begin
      // Topic longer than the body it sits in.
      tl = $urandom_range(1, 10);
      n = $urandom_range(0, tl - 1);
      decl = 32'(3 + n);
    end else if (mode < 80) begin
      n = tl + $urandom_range(0, 8);
      decl = 32'(3 + n);
      if ($urandom_range(0, 1) == 0) decl = $urandom();
      else decl = decl ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      framed = 1'b0;
      if (mode < 88) begin
        decl = 32'($urandom_range(0, 2));
        n = 4 + decl;
      end else if (mode < 95) begin
        decl = $urandom();
        n = $urandom_range(1, 7);
      end else begin
        decl = $urandom();
        n = $urandom_range(1, 14);
      end
    end
    if (framed) begin
      if ($urandom_range(0, 3) == 0) prio = 8'($urandom());
      else prio = 8'($urandom_range(0, int'(cur_max_prio)));
      fb = '{decl[31:24], decl[23:16], decl[15:8], decl[7:0], prio,
             8'(tl >> 8), 8'(tl)};
      repeat (n) fb.push_back(8'($urandom()));
    end else begin
      // Raw bytes; a short body still carries its prefix.
      if (mode < 88) begin
        fb = '{decl[31:24], decl[23:16], decl[15:8], decl[7:0]};
        repeat (n - 4) fb.push_back(8'($urandom()));
      end else begin
        repeat (n) fb.push_back(8'($urandom()));
      end
    end
    send_frame(fb);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_priority(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_max_priority(v);
    cur_max_prio = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int nbytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_random_frame();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset priority limit.
    send_frame('{8'h5A});
    send_frame('{8'h00, 8'h00, 8'h00, 8'h00});
    send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA5});
    send_frame('{8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h01});
    send_frame('{8'h00, 8'h00, 8'h00, 8'h04, 8'h03, 8'hFF, 8'hFF, 8'h7E});
    run_random(PHASE_BYTES);
    wait_drained();

    write_max_priority(8'h00);
    send_idle_pct = 54;
    recv_stall_pct = 0;
    run_random(PHASE_BYTES);
    wait_drained();

    write_max_priority(8'hFF);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    run_random(PHASE_BYTES);
    wait_drained();

    write_max_priority(8'($urandom_range(1, 254)));
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_random(PHASE_BYTES);
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
